// File: hw/rtl/sdtt_pkg.sv
// Package for the sleep deadline timer table.
// Holds opcodes, result kinds, register indexes and the controller/datapath structs.
// No dependencies.
package sdtt_pkg;

    localparam int PeriodW = 48;
    localparam int TimeW   = 64;
    localparam int ClientW = 8;

    localparam logic [PeriodW-1:0] RESET_PERIOD = 48'd54925000;

    localparam logic [1:0] OP_OVERFLOW = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_SLEEP    = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] KIND_TIME   = 2'd0;
    localparam logic [1:0] KIND_WAKE   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_DOWN   = 1'b1;

    typedef struct packed {
        logic load;
        logic step_base;
        logic scan_init;
        logic calc_now;
        logic sleep;
        logic scan_issue;
        logic report;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       can_issue;
        logic       pipe_empty;
    } dp_status_t;

endpackage

// File: hw/rtl/sdtt_ctrl.sv
// Controller state machine for the sleep deadline timer table.
// Depends on sdtt_pkg for the command and status structs.
module sdtt_ctrl
    import sdtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  dp_status_t status,
    output ctl_cmd_t   cmd,
    output logic       busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PART   = 3'd1;
    localparam logic [2:0] ST_NOW    = 3'd2;
    localparam logic [2:0] ST_SLEEP  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_REPORT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // An unused opcode is taken and dropped without any result.
                if (start && (opcode != OP_NONE))
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PART;
                end
            end
            ST_PART:
            begin
                cmd.step_base = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = ST_NOW;
            end
            ST_NOW:
            begin
                cmd.calc_now = 1'b1;
                state_next   = (status.op == OP_SLEEP) ? ST_SLEEP : ST_SCAN;
            end
            ST_SLEEP:
            begin
                cmd.sleep  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.can_issue)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (status.pipe_empty)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: hw/rtl/sdtt_dpath.sv
// Datapath for the sleep deadline timer table: time base, waiter memory,
// compacting scan and result registers. Depends on sdtt_pkg.
module sdtt_dpath
    import sdtt_pkg::*;
#(
    parameter int MAX_WAITERS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_cmd_t           cmd,
    output dp_status_t         status,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [PeriodW-1:0] wr_data,
    input  logic [1:0]         opcode,
    input  logic [PeriodW-1:0] raw_count,
    input  logic [ClientW-1:0] client_id,
    input  logic [PeriodW-1:0] wait_time,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic [ClientW-1:0] woken_client,
    output logic [TimeW-1:0]   now_time,
    output logic               last
);

    localparam int CntW = $clog2(MAX_WAITERS + 1);
    localparam int IdxW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_WAITERS);

    logic [PeriodW-1:0] period_reg;
    logic               down_reg;
    logic [TimeW-1:0]   time_base_reg;
    logic [CntW-1:0]    count_reg;

    logic [1:0]         op_reg;
    logic [PeriodW-1:0] raw_reg;
    logic [ClientW-1:0] client_reg;
    logic [PeriodW-1:0] wait_reg;
    logic [PeriodW-1:0] part_reg;
    logic [TimeW-1:0]   now_reg;

    logic [CntW-1:0]    rd_ptr_reg;
    logic [CntW-1:0]    keep_reg;
    logic               q_valid_reg;
    logic [TimeW-1:0]   dl_q_reg;
    logic [ClientW-1:0] own_q_reg;

    logic [TimeW-1:0]   dl_mem [MAX_WAITERS];
    logic [ClientW-1:0] own_mem [MAX_WAITERS];

    logic [PeriodW-1:0] clamped;
    logic               full;
    logic               expired;

    logic               strobe_reg;
    logic [1:0]         kind_reg;
    logic [ClientW-1:0] client_out_reg;
    logic [TimeW-1:0]   now_out_reg;
    logic               last_reg;

    assign clamped = (raw_reg > period_reg) ? period_reg : raw_reg;
    assign full    = (count_reg >= CntMax);
    assign expired = (dl_q_reg <= now_reg);

    assign status.op         = op_reg;
    assign status.can_issue  = (rd_ptr_reg < count_reg);
    assign status.pipe_empty = !q_valid_reg;

    // Configuration, time base, table fill count and scan pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= RESET_PERIOD;
            down_reg      <= 1'b0;
            time_base_reg <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            keep_reg      <= '0;
            q_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_PERIOD)
                begin
                    period_reg <= wr_data;
                end
                else if (wr_index == REG_DOWN)
                begin
                    down_reg <= wr_data[0];
                end
            end
            if (cmd.step_base && (op_reg == OP_OVERFLOW))
            begin
                time_base_reg <= time_base_reg + {{(TimeW - PeriodW){1'b0}}, period_reg};
            end
            if (cmd.sleep && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.report)
            begin
                count_reg <= keep_reg;
            end
            if (cmd.scan_init)
            begin
                rd_ptr_reg <= '0;
                keep_reg   <= '0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                if (q_valid_reg && !expired)
                begin
                    keep_reg <= keep_reg + 1'b1;
                end
            end
            q_valid_reg <= cmd.scan_issue;
        end
    end

    // Item registers and the time arithmetic, one step a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            raw_reg    <= raw_count;
            client_reg <= client_id;
            wait_reg   <= wait_time;
        end
        if (cmd.step_base)
        begin
            part_reg <= down_reg ? (period_reg - clamped) : raw_reg;
        end
        if (cmd.calc_now)
        begin
            now_reg <= time_base_reg + {{(TimeW - PeriodW){1'b0}}, part_reg};
        end
    end

    // Waiter memory. The compaction write index never reaches the read index,
    // so a kept entry never overwrites one that is still to be read.
    always_ff @(posedge clk)
    begin
        if (cmd.sleep && !full)
        begin
            dl_mem[count_reg[IdxW-1:0]]  <= now_reg + {{(TimeW - PeriodW){1'b0}}, wait_reg};
            own_mem[count_reg[IdxW-1:0]] <= client_reg;
        end
        else if (q_valid_reg && !expired)
        begin
            dl_mem[keep_reg[IdxW-1:0]]  <= dl_q_reg;
            own_mem[keep_reg[IdxW-1:0]] <= own_q_reg;
        end
        if (cmd.scan_issue)
        begin
            dl_q_reg  <= dl_mem[rd_ptr_reg[IdxW-1:0]];
            own_q_reg <= own_mem[rd_ptr_reg[IdxW-1:0]];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.report || cmd.sleep || (q_valid_reg && expired);
        end
    end

    always_ff @(posedge clk)
    begin
        now_out_reg <= now_reg;
        if (cmd.report)
        begin
            kind_reg       <= KIND_TIME;
            client_out_reg <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.sleep)
        begin
            kind_reg       <= full ? KIND_REJECT : KIND_ACCEPT;
            client_out_reg <= client_reg;
            last_reg       <= 1'b1;
        end
        else
        begin
            kind_reg       <= KIND_WAKE;
            client_out_reg <= own_q_reg;
            last_reg       <= 1'b0;
        end
    end

    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign woken_client = client_out_reg;
    assign now_time     = now_out_reg;
    assign last         = last_reg;

endmodule

// File: hw/rtl/sleep_deadline_timer_table_top.sv
// Sleep deadline timer table, top level.
// A command is transferred at a rising edge with start high and busy low;
// it carries opcode, raw_count, client_id and wait_time. Opcode 3 is taken
// and dropped. Results leave one per cycle on kind, woken_client, now_time
// and last, each valid for the single cycle that strobe is high; the
// receiver cannot stall them, and last marks the final result of a command.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once and
// belong only to idle periods: index 0 is the overflow period, index 1 the
// count-down flag.
// A sleep request gives its single result from the SLEEP state, after the
// PART and NOW steps. An overflow or tick event walks the N stored waiters
// through the memory read port, one entry a cycle, giving a wake result for
// each expired waiter; the time report comes last. busy stays high through
// the scan, so no new command is taken before it ends and the scan over the
// memory port sets the rate.
// Reset clears the time base, empties the table and restores the default
// period and an up-counting timer; no clearing pass is needed.
// Depends on sdtt_pkg, sdtt_ctrl and sdtt_dpath.
module sleep_deadline_timer_table_top
    import sdtt_pkg::*;
#(
    parameter int MAX_WAITERS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [PeriodW-1:0] raw_count,
    input  logic [ClientW-1:0] client_id,
    input  logic [PeriodW-1:0] wait_time,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [PeriodW-1:0] wr_data,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic [ClientW-1:0] woken_client,
    output logic [TimeW-1:0]   now_time,
    output logic               last
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    sdtt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sdtt_dpath #(
        .MAX_WAITERS (MAX_WAITERS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .opcode       (opcode),
        .raw_count    (raw_count),
        .client_id    (client_id),
        .wait_time    (wait_time),
        .strobe       (strobe),
        .kind         (kind),
        .woken_client (woken_client),
        .now_time     (now_time),
        .last         (last)
    );

endmodule

// File: tb/sleep_deadline_timer_table_top_tb.sv
// Self-checking testbench for the sleep deadline timer table.
// Drives commands and register writes, predicts every result and checks each strobe.
// Depends on sdtt_pkg and sleep_deadline_timer_table_top.
module sleep_deadline_timer_table_top_tb;
    import sdtt_pkg::*;

    localparam int WAITERS     = 16;
    localparam int DRAIN       = WAITERS + 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 85;
    localparam int ROWS        = 21;

    localparam logic [PeriodW-1:0] ALL48 = '1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ClientW-1:0] client;
        logic [TimeW-1:0]   now;
        logic               last;
    } outcome_t;

    typedef struct packed {
        logic               is_cfg;
        logic               cfg_idx;
        logic [PeriodW-1:0] cfg_val;
        logic [1:0]         op;
        logic [PeriodW-1:0] raw;
        logic [ClientW-1:0] cid;
        logic [PeriodW-1:0] wt;
        logic [4:0]         reps;
        logic               typed;
        outcome_t           want;
    } script_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [PeriodW-1:0] raw_count;
    logic [ClientW-1:0] client_id;
    logic [PeriodW-1:0] wait_time;
    logic               wr_en;
    logic               wr_index;
    logic [PeriodW-1:0] wr_data;
    logic               strobe;
    logic [1:0]         kind;
    logic [ClientW-1:0] woken_client;
    logic [TimeW-1:0]   now_time;
    logic               last;

    // Shadow copy of the block's configuration and waiter table.
    logic [PeriodW-1:0] period_ns;
    logic               down_mode;
    logic [TimeW-1:0]   base_ns;
    logic [TimeW-1:0]   deadline_ns [WAITERS];
    logic [ClientW-1:0] sleeper [WAITERS];
    int                 sleeper_count;

    outcome_t table_results_q [$];
    int       fail_count;
    int       burst_left;
    int       quiet_cycles = 0;

    // Directed commands; rows with a typed outcome are checked against it directly.
    script_row_t script [ROWS] = '{
        '{1'b0, REG_PERIOD, 48'd0, OP_TICK, 48'd0, 8'h00, 48'd0, 5'd1,
          1'b1, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_TICK, ALL48, 8'h00, 48'd0, 5'd1,
          1'b1, '{KIND_TIME, 8'h00, 64'h0000_FFFF_FFFF_FFFF, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_SLEEP, 48'd0, 8'hFF, 48'd0, 5'd1,
          1'b1, '{KIND_ACCEPT, 8'hFF, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_SLEEP, 48'd0, 8'h00, ALL48, 5'd1,
          1'b1, '{KIND_ACCEPT, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_TICK, 48'd5, 8'h00, 48'd0, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_OVERFLOW, 48'd0, 8'h00, 48'd0, 5'd1,
          1'b1, '{KIND_TIME, 8'h00, 64'd54925000, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_SLEEP, 48'd0, 8'h01, ALL48, 5'd15,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_SLEEP, 48'd0, 8'hAA, 48'd77, 5'd1,
          1'b1, '{KIND_REJECT, 8'hAA, 64'd54925000, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_NONE, ALL48, 8'h55, ALL48, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_TICK, ALL48, 8'h00, 48'd0, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b1, REG_DOWN, 48'd1, OP_NONE, 48'd0, 8'h00, 48'd0, 5'd0,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b1, REG_PERIOD, 48'd1000, OP_NONE, 48'd0, 8'h00, 48'd0, 5'd0,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_TICK, 48'd2000, 8'h00, 48'd0, 5'd1,
          1'b1, '{KIND_TIME, 8'h00, 64'd54925000, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_TICK, 48'd0, 8'h00, 48'd0, 5'd1,
          1'b1, '{KIND_TIME, 8'h00, 64'd54926000, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_OVERFLOW, 48'd1000, 8'h00, 48'd0, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b1, REG_PERIOD, 48'd0, OP_NONE, 48'd0, 8'h00, 48'd0, 5'd0,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_OVERFLOW, 48'd7, 8'h00, 48'd0, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b1, REG_DOWN, 48'd0, OP_NONE, 48'd0, 8'h00, 48'd0, 5'd0,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_OVERFLOW, 48'd3, 8'h00, 48'd0, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b1, REG_PERIOD, ALL48, OP_NONE, 48'd0, 8'h00, 48'd0, 5'd0,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}},
        '{1'b0, REG_PERIOD, 48'd0, OP_OVERFLOW, 48'd0, 8'h00, 48'd0, 5'd1,
          1'b0, '{KIND_TIME, 8'h00, 64'd0, 1'b1}}
    };

    sleep_deadline_timer_table_top #(
        .MAX_WAITERS (WAITERS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .raw_count    (raw_count),
        .client_id    (client_id),
        .wait_time    (wait_time),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .strobe       (strobe),
        .kind         (kind),
        .woken_client (woken_client),
        .now_time     (now_time),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [PeriodW-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PeriodW-1:0];
    endfunction

    function automatic logic [TimeW-1:0] clock_now(logic [PeriodW-1:0] raw);
        logic [PeriodW-1:0] part;
        part = raw;
        if (down_mode)
        begin
            if (part > period_ns)
                part = period_ns;
            part = period_ns - part;
        end
        return base_ns + {16'd0, part};
    endfunction

    // Applies one command to the shadow table and queues the results it causes.
    function automatic void timer_table_step(logic [1:0] op, logic [PeriodW-1:0] raw,
                                             logic [ClientW-1:0] cid,
                                             logic [PeriodW-1:0] wt);
        logic [TimeW-1:0] now;
        int               keep;
        if (op == OP_NONE)
            return;
        if (op == OP_SLEEP)
        begin
            now = clock_now(raw);
            if (sleeper_count >= WAITERS)
                table_results_q.push_back('{KIND_REJECT, cid, now, 1'b1});
            else
            begin
                deadline_ns[sleeper_count] = now + {16'd0, wt};
                sleeper[sleeper_count]     = cid;
                sleeper_count++;
                table_results_q.push_back('{KIND_ACCEPT, cid, now, 1'b1});
            end
            return;
        end
        if (op == OP_OVERFLOW)
            base_ns = base_ns + {16'd0, period_ns};
        now  = clock_now(raw);
        keep = 0;
        for (int i = 0; i < sleeper_count; i++)
        begin
            if (deadline_ns[i] <= now)
                table_results_q.push_back('{KIND_WAKE, sleeper[i], now, 1'b0});
            else
            begin
                deadline_ns[keep] = deadline_ns[i];
                sleeper[keep]     = sleeper[i];
                keep++;
            end
        end
        sleeper_count = keep;
        table_results_q.push_back('{KIND_TIME, 8'h00, now, 1'b1});
    endfunction

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endfunction

    // Unless dense is set, holds the sender in random bursts; then waits for the command transfer and for busy to fall.
    task automatic send_command(logic [1:0] op, logic [PeriodW-1:0] raw,
                                logic [ClientW-1:0] cid, logic [PeriodW-1:0] wt,
                                bit dense);
        int gap;
        if (!dense)
        begin
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                burst_left = $urandom_range(1, 24);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        opcode    <= op;
        raw_count <= raw;
        client_id <= cid;
        wait_time <= wt;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        timer_table_step(op, raw, cid, wt);
    endtask

    // Stops sending until every queued result has come, then lets a scan finish.
    task automatic drain_table();
        start <= 1'b0;
        @(posedge clk);
        while (table_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [PeriodW-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_PERIOD)
            period_ns = val;
        else
            down_mode = val[0];
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && strobe)
        begin
            if (table_results_q.size() == 0)
                note_failure($sformatf("unexpected result: kind %0d client %0d now %0h",
                                       kind, woken_client, now_time));
            else
            begin
                e = table_results_q.pop_front();
                if (kind !== e.kind || woken_client !== e.client ||
                    now_time !== e.now || last !== e.last)
                    note_failure($sformatf(
                        "mismatch: got kind %0d client %0d now %0h last %0b, want %0d %0d %0h %0b",
                        kind, woken_client, now_time, last,
                        e.kind, e.client, e.now, e.last));
            end
        end
    end

    // Ends the run if neither a transfer nor a result happens for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [1:0]         op;
        logic [PeriodW-1:0] raw;
        logic [PeriodW-1:0] wt;
        logic [PeriodW-1:0] per;
        logic [ClientW-1:0] cid;
        logic               down;
        int                 counted;
        int                 pick;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        opcode       <= OP_TICK;
        raw_count    <= '0;
        client_id    <= '0;
        wait_time    <= '0;
        wr_en        <= 1'b0;
        wr_index     <= REG_PERIOD;
        wr_data      <= '0;
        fail_count    = 0;
        burst_left    = 0;
        period_ns     = RESET_PERIOD;
        down_mode     = 1'b0;
        base_ns       = '0;
        sleeper_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
        begin
            if (script[r].is_cfg)
            begin
                drain_table();
                write_reg(script[r].cfg_idx, script[r].cfg_val);
            end
            else
            begin
                for (int k = 0; k < script[r].reps; k++)
                begin
                    send_command(script[r].op, script[r].raw, script[r].cid + 8'(k),
                                 script[r].wt, 1'b0);
                    if (script[r].typed)
                        table_results_q[table_results_q.size() - 1] = script[r].want;
                end
            end
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    per  = ALL48;
                    down = 1'b0;
                end
                1:
                begin
                    per  = 48'($urandom_range(1, 100000));
                    down = 1'b1;
                end
                2:
                begin
                    per  = '0;
                    down = 1'b1;
                end
                default:
                begin
                    per  = rand48();
                    down = 1'($urandom_range(0, 1));
                end
            endcase
            drain_table();
            write_reg(REG_PERIOD, per);
            write_reg(REG_DOWN, {47'd0, down});
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = OP_SLEEP;
                else if (pick < 75)
                    op = OP_TICK;
                else if (pick < 90)
                    op = OP_OVERFLOW;
                else
                    op = OP_NONE;
                case ($urandom_range(0, 3))
                    0:       raw = rand48();
                    1:       raw = 48'($urandom_range(0, 5000));
                    2:       raw = period_ns + 48'($urandom_range(0, 2)) - 48'd1;
                    default: raw = ALL48;
                endcase
                case ($urandom_range(0, 3))
                    0:       wt = 48'($urandom_range(0, 3000));
                    1:       wt = rand48();
                    2:       wt = ALL48;
                    default: wt = '0;
                endcase
                cid = 8'($urandom);
                if ($urandom_range(0, 39) == 0)
                    drain_table();
                send_command(op, raw, cid, wt, 1'b0);
                if (op != OP_NONE)
                    counted++;
            end
        end

        drain_table();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sdtt_pkg.sv
hw/rtl/sdtt_ctrl.sv
hw/rtl/sdtt_dpath.sv
hw/rtl/sleep_deadline_timer_table_top.sv
tb/sleep_deadline_timer_table_top_tb.sv
